FILE: rtl/tlt_pkg.sv
package tlt_pkg;

  typedef enum logic [1:0] {
    OP_MATCH = 2'd0,
    OP_NEW   = 2'd1,
    OP_EOF   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    TS_NEW     = 2'd0,
    TS_TRACKED = 2'd1,
    TS_LOST    = 2'd2
  } trk_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_NONE  = 2'd3
  } stat_e;

  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_MATCH = 3'd1,
    CMD_ALLOC = 3'd2,
    CMD_AGE   = 3'd3,
    CMD_SHIFT = 3'd4
  } cmd_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_LIMIT = 2'd1;

  localparam logic [15:0] TRACKED_MIN_HITS = 16'd2;
  localparam logic [15:0] SAT16 = 16'hFFFF;
  localparam logic [7:0]  SAT8  = 8'hFF;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [4:0]         slot;
    logic [7:0]         member_id;
    logic signed [15:0] score;
  } in_t;

  typedef struct packed {
    logic [4:0]  out_slot;
    logic [31:0] track_id;
    logic [15:0] hits;
    logic [15:0] age;
    logic [1:0]  track_state;
    logic [7:0]  out_member;
    logic        member_valid;
    logic [1:0]  status;
    logic        last;
  } res_t;

  typedef struct packed {
    logic valid;
    logic matched;
    logic created;
    logic pending;
  } ent_ctl_t;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] hits;
    logic [15:0] age;
    logic [7:0]  lost_age;
    logic [1:0]  state;
    logic [7:0]  member;
  } ent_dat_t;

  typedef struct packed {
    ent_ctl_t ctl;
    ent_dat_t dat;
  } entry_t;

  typedef struct packed {
    cmd_e        kind;
    logic [7:0]  member;
    logic [31:0] new_id;
    logic [3:0]  lost_limit;
  } cell_cmd_t;

endpackage

FILE: rtl/track_lifecycle_table.sv
// Track table of MAX_TRACKS entries, one per cell in a ring of cells. For a match report or a
// new detection the cells update on the accepting edge and the result is read out of the
// addressed cell in ST_ONE once the output register is free. An end-of-frame item ages all
// cells and then rotates the ring once around, with slot order presented at cell 0; a shift
// that reports a track waits while the output is stalled, and if no track was reported a
// blank NONE result follows. Input is taken again once the item is finished, while the
// last result may still wait in the output register.
module track_lifecycle_table #(
  parameter int MAX_TRACKS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  tlt_pkg::in_t                       in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output tlt_pkg::res_t                      out_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tlt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tlt_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import tlt_pkg::*;

  localparam int IdxW = $clog2(MAX_TRACKS);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ONE  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_NONE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [4:0]      slot_q, slot_d;
  stat_e           stat_q, stat_d;
  logic [IdxW-1:0] rot_q, rot_d;
  logic            found_q, found_d;
  logic            out_valid_q, out_valid_d;
  res_t            out_q, out_d;
  logic [9:0]      thr_q;
  logic [3:0]      lim_q;
  logic [31:0]     next_id_q, next_id_d;

  entry_t          ent [MAX_TRACKS];
  entry_t          nbr [MAX_TRACKS];
  entry_t          wrap;
  logic [MAX_TRACKS:0]   taken;
  logic [MAX_TRACKS-1:0] take;
  logic [MAX_TRACKS-1:0] sel;
  logic [MAX_TRACKS-1:0] pend;
  cell_cmd_t       cmd;

  logic            in_accept;
  logic            out_free;
  logic            in_range;
  logic [IdxW-1:0] sidx;
  logic [IdxW-1:0] ridx;
  logic [IdxW-1:0] alloc_idx;
  logic            full;
  logic signed [16:0] score_x;
  logic signed [16:0] thr_x;
  logic            pass;
  logic            head_last;

  function automatic res_t put_track(entry_t e, logic [4:0] s);
    res_t r;
    logic mv;
    mv             = (e.dat.state != TS_LOST);
    r.out_slot     = s;
    r.track_id     = e.dat.id;
    r.hits         = e.dat.hits;
    r.age          = e.dat.age;
    r.track_state  = e.dat.state;
    r.out_member   = mv ? e.dat.member : 8'd0;
    r.member_valid = mv;
    r.status       = STAT_OK;
    r.last         = 1'b0;
    return r;
  endfunction

  function automatic res_t put_blank(logic [4:0] s, stat_e st);
    res_t r;
    r          = '0;
    r.out_slot = s;
    r.status   = st;
    r.last     = 1'b1;
    return r;
  endfunction

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign cfg_ready_o = 1'b1;

  assign in_range = (int'(in_i.slot) < MAX_TRACKS);
  assign sidx     = IdxW'(in_i.slot);
  assign ridx     = IdxW'(slot_q);
  assign score_x  = {in_i.score[15], in_i.score};
  assign thr_x    = {7'd0, thr_q};
  assign pass     = (score_x >= thr_x);
  assign full     = ~taken[MAX_TRACKS];
  assign taken[0] = 1'b0;

  always_comb begin
    alloc_idx = '0;
    for (int k = 0; k < MAX_TRACKS; k++) begin
      if (take[k]) begin
        alloc_idx = alloc_idx | IdxW'(k);
      end
      sel[k]  = (sidx == IdxW'(k));
      pend[k] = ent[k].ctl.pending;
    end
  end

  // Nothing pending behind the head means this report is the last of the frame.
  assign head_last = ~(|(pend >> 1));

  // The head that leaves cell 0 has been reported; an expired lost track drops out.
  always_comb begin
    wrap = ent[0];
    if (ent[0].ctl.pending) begin
      wrap.ctl.pending = 1'b0;
      if (ent[0].dat.state == TS_LOST) begin
        wrap.ctl.valid = 1'b0;
      end
    end
  end

  for (genvar k = 0; k < MAX_TRACKS; k++) begin : g_cell
    if (k == MAX_TRACKS - 1) begin : g_tail
      assign nbr[k] = wrap;
    end else begin : g_mid
      assign nbr[k] = ent[k+1];
    end

    tlt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .sel_i   (sel[k]),
      .taken_i (taken[k]),
      .taken_o (taken[k+1]),
      .take_o  (take[k]),
      .nbr_i   (nbr[k]),
      .ent_o   (ent[k])
    );
  end

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    stat_d      = stat_q;
    rot_d       = rot_q;
    found_d     = found_q;
    next_id_d   = next_id_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & out_stall_i;
    cmd.kind       = CMD_IDLE;
    cmd.member     = in_i.member_id;
    cmd.new_id     = next_id_q + 32'd1;
    cmd.lost_limit = lim_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_i.opcode)
            OP_MATCH: begin
              slot_d  = in_i.slot;
              state_d = ST_ONE;
              if (in_range && ent[sidx].ctl.valid) begin
                stat_d = STAT_OK;
                if (pass) begin
                  cmd.kind = CMD_MATCH;
                end
              end else begin
                stat_d = STAT_EMPTY;
              end
            end
            OP_NEW: begin
              state_d  = ST_ONE;
              cmd.kind = CMD_ALLOC;
              if (full) begin
                stat_d = STAT_FULL;
                slot_d = 5'd0;
              end else begin
                stat_d    = STAT_OK;
                slot_d    = 5'(alloc_idx);
                next_id_d = next_id_q + 32'd1;
              end
            end
            OP_EOF: begin
              cmd.kind = CMD_AGE;
              rot_d    = '0;
              found_d  = 1'b0;
              state_d  = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_ONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (stat_q == STAT_OK) begin
            out_d      = put_track(ent[ridx], slot_q);
            out_d.last = 1'b1;
          end else begin
            out_d = put_blank(slot_q, stat_q);
          end
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!ent[0].ctl.pending || out_free) begin
          cmd.kind = CMD_SHIFT;
          rot_d    = rot_q + 1'b1;
          if (ent[0].ctl.pending) begin
            out_valid_d = 1'b1;
            out_d       = put_track(ent[0], 5'(rot_q));
            out_d.last  = head_last;
            found_d     = 1'b1;
          end
          if (rot_q == IdxW'(MAX_TRACKS - 1)) begin
            rot_d   = '0;
            state_d = (found_q || ent[0].ctl.pending) ? ST_IDLE : ST_NONE;
          end
        end
      end
      ST_NONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = put_blank(5'd0, STAT_NONE);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rot_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      next_id_q   <= '0;
      stat_q      <= STAT_OK;
      thr_q       <= 10'd500;
      lim_q       <= 4'd5;
    end else begin
      state_q     <= state_d;
      rot_q       <= rot_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      next_id_q   <= next_id_d;
      stat_q      <= stat_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_THRESHOLD:  thr_q <= cfg_data_i;
          REG_LOST_LIMIT: lim_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    out_q  <= out_d;
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state is not one-hot");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (pend == '0))
    else $error("a track is still pending report while idle");

  a_blank_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != STAT_OK) |-> out_q.last)
    else $error("a status result is not marked last");

  a_id_only_on_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_id_q != $past(next_id_q)) |-> $past(in_accept && in_i.opcode == OP_NEW))
    else $error("track id counter moved without a new detection");

endmodule

FILE: rtl/tlt_cell.sv
module tlt_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tlt_pkg::cell_cmd_t cmd_i,
  input  logic               sel_i,
  input  logic               taken_i,
  output logic               taken_o,
  output logic               take_o,
  input  tlt_pkg::entry_t    nbr_i,
  output tlt_pkg::entry_t    ent_o
);
  import tlt_pkg::*;

  ent_ctl_t ctl_q, ctl_d;
  ent_dat_t dat_q, dat_d;
  entry_t   cur;
  entry_t   nxt;
  logic [15:0] hits_inc;

  assign cur     = '{ctl: ctl_q, dat: dat_q};
  assign ent_o   = cur;
  assign taken_o = taken_i | ~ctl_q.valid;
  assign take_o  = (cmd_i.kind == CMD_ALLOC) & ~taken_i & ~ctl_q.valid;
  assign hits_inc = (dat_q.hits == SAT16) ? SAT16 : dat_q.hits + 16'd1;

  always_comb begin
    nxt = cur;
    case (cmd_i.kind)
      CMD_SHIFT: begin
        nxt = nbr_i;
      end
      CMD_MATCH: begin
        if (sel_i) begin
          nxt.dat.age      = (dat_q.age == SAT16) ? SAT16 : dat_q.age + 16'd1;
          nxt.dat.hits     = hits_inc;
          if (hits_inc >= TRACKED_MIN_HITS) begin
            nxt.dat.state = TS_TRACKED;
          end
          nxt.dat.lost_age = 8'd0;
          nxt.dat.member   = cmd_i.member;
          nxt.ctl.matched  = 1'b1;
        end
      end
      CMD_ALLOC: begin
        if (take_o) begin
          nxt.ctl.valid    = 1'b1;
          nxt.ctl.created  = 1'b1;
          nxt.ctl.matched  = 1'b0;
          nxt.dat.id       = cmd_i.new_id;
          nxt.dat.age      = 16'd1;
          nxt.dat.hits     = 16'd1;
          nxt.dat.lost_age = 8'd0;
          nxt.dat.state    = TS_NEW;
          nxt.dat.member   = cmd_i.member;
        end
      end
      CMD_AGE: begin
        if (ctl_q.valid && !ctl_q.matched && !ctl_q.created) begin
          nxt.dat.state    = TS_LOST;
          nxt.dat.lost_age = (dat_q.lost_age == SAT8) ? SAT8 : dat_q.lost_age + 8'd1;
          nxt.dat.age      = (dat_q.age == SAT16) ? SAT16 : dat_q.age + 16'd1;
        end
        nxt.ctl.matched = 1'b0;
        nxt.ctl.created = 1'b0;
        // The entry is reported while alive, or once when it expires.
        nxt.ctl.pending = ctl_q.valid & ((nxt.dat.state != TS_LOST) |
                          (nxt.dat.lost_age > {4'd0, cmd_i.lost_limit}));
      end
      default: ;
    endcase
  end

  assign ctl_d = nxt.ctl;
  assign dat_d = nxt.dat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dat_q <= dat_d;
  end

endmodule
